/* hdl/rcc_pkg.sv */
// ----------------------------------------------------------------------------
// rcc_pkg: shared types, constants and tables of the rainbow color cycler
// Holds the register map, the sequencer state and operand codes, the control
// bundle from the sequencer to the datapath, and the raised-sine level table.
// ----------------------------------------------------------------------------
package rcc_pkg;

  // Default phase accumulator width, Q0.PHASE_BITS
  localparam int PHASE_BITS_DEF = 16;

  // Sine table geometry
  localparam int SINE_TABLE_ENTRIES = 256;
  localparam int SINE_IDX_BITS      = $clog2(SINE_TABLE_ENTRIES);

  // Q1.15 one
  localparam logic [15:0] ONE_Q15 = 16'h8000;

  // 2*pi in Q30
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  // Configuration register map
  localparam int          CFG_IDX_W          = 3;
  localparam logic [2:0]  REG_MIN_BRIGHTNESS = 3'd0;
  localparam logic [2:0]  REG_MAX_BRIGHTNESS = 3'd1;
  localparam logic [2:0]  REG_BRIGHT_SPEED   = 3'd2;
  localparam logic [2:0]  REG_MIN_SATURATION = 3'd3;
  localparam logic [2:0]  REG_MAX_SATURATION = 3'd4;
  localparam logic [2:0]  REG_SAT_SPEED      = 3'd5;

  // Color channel slots walked by the sequencer
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,   // wait for a tick
    ST_MB,     // step * brightness speed
    ST_MS,     // step * saturation speed, advance brightness phase
    ST_B0,     // advance saturation phase, min brightness term
    ST_B1,     // max brightness term
    ST_S0,     // brightness level, min saturation term
    ST_S1,     // max saturation term
    ST_SAT,    // saturation level
    ST_CA,     // blend product for current channel
    ST_CB,     // blended value
    ST_CC,     // scale product for current channel
    ST_FIN     // hand result to the output register
  } state_t;

  // Shared multiplier operand selects
  typedef enum logic [2:0] {
    MOP_BSPD,
    MOP_SSPD,
    MOP_BMIN,
    MOP_BMAX,
    MOP_SMIN,
    MOP_SMAX,
    MOP_BLEND,
    MOP_SCALE
  } mop_t;

  // Control bundle, sequencer to datapath
  typedef struct packed {
    logic       busy;
    logic       ld_step;
    logic       mul_en;
    mop_t       mop;
    logic       upd_bp;
    logic       upd_sp;
    logic       ld_acc;
    logic       ld_bright;
    logic       ld_sat;
    logic       ld_v;
    logic       ld_res;
    logic       ld_out;
    logic [1:0] chan;
  } ctl_t;

  // Table of u = (sin + 1) / 2 in Q1.15, one entry per table index
  typedef logic [SINE_TABLE_ENTRIES-1:0][15:0] sine_tab_t;

  function automatic sine_tab_t build_sine_table();
    sine_tab_t   tab;
    logic [63:0] t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] negs;
    logic        neg;
    longint      sum;
    longint      s;
    for (int i = 0; i < SINE_TABLE_ENTRIES; i++) begin
      t   = 64'(i) << (32 - SINE_IDX_BITS);
      neg = 1'b0;
      if (t >= 64'h8000_0000) begin
        neg = 1'b1;
        t   = t - 64'h8000_0000;
      end
      if (t > 64'h4000_0000) t = 64'h8000_0000 - t;
      x    = (t * TWO_PI_Q30) >> 32;
      x2   = (x * x) >> 30;
      term = x;
      pos  = x;
      negs = 64'd0;
      // Taylor terms, divisors (2k)(2k+1)
      for (int k = 1; k <= 5; k++) begin
        case (k)
          1:       term = ((term * x2) >> 30) / 64'd6;
          2:       term = ((term * x2) >> 30) / 64'd20;
          3:       term = ((term * x2) >> 30) / 64'd42;
          4:       term = ((term * x2) >> 30) / 64'd72;
          default: term = ((term * x2) >> 30) / 64'd110;
        endcase
        if ((k % 2) == 1) negs = negs + term;
        else              pos  = pos + term;
      end
      sum = longint'(pos) - longint'(negs);
      if (sum < 0) sum = 0;
      sum = (sum + 16384) >>> 15;
      if (sum > 32768) sum = 32768;
      s = neg ? -sum : sum;
      tab[i] = 16'((s + 32768) >>> 1);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_U_TABLE = build_sine_table();

  // Level from the weighted sum, saturated at one
  function automatic logic [15:0] level_sat(input logic [32:0] sum);
    logic [17:0] q;
    q = sum[32:15];
    return (q > 18'(ONE_Q15)) ? ONE_Q15 : q[15:0];
  endfunction

endpackage

/* hdl/rcc_mul.sv */
// ----------------------------------------------------------------------------
// rcc_mul: shared multiplier with registered product
// One unsigned multiply per enabled cycle; the product holds otherwise.
// ----------------------------------------------------------------------------
module rcc_mul #(
  parameter int A_W = 16,
  parameter int B_W = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);

  logic [A_W+B_W-1:0] p_r;

  // Product register, loaded only when an operation is issued
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

  assign p = p_r;

endmodule

/* hdl/rcc_seq.sv */
// ----------------------------------------------------------------------------
// rcc_seq: sequencer of the rainbow color cycler
// Steps one tick through phase advance, level computation and the three
// channel blends, issuing at most one multiply per step on the shared unit.
// ----------------------------------------------------------------------------
module rcc_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_hold,
  output rcc_pkg::ctl_t ctl
);
  import rcc_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] chan_r, chan_nxt;

  // State and channel registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      chan_r  <= CH_RED;
    end else begin
      state_r <= state_nxt;
      chan_r  <= chan_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    chan_nxt  = chan_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MB;
      ST_MB:   state_nxt = ST_MS;
      ST_MS:   state_nxt = ST_B0;
      ST_B0:   state_nxt = ST_B1;
      ST_B1:   state_nxt = ST_S0;
      ST_S0:   state_nxt = ST_S1;
      ST_S1:   state_nxt = ST_SAT;
      ST_SAT: begin
        state_nxt = ST_CA;
        chan_nxt  = CH_RED;
      end
      ST_CA:   state_nxt = ST_CB;
      ST_CB:   state_nxt = ST_CC;
      ST_CC: begin
        if (chan_r == CH_BLUE) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_CA;
          chan_nxt  = chan_r + 2'd1;
        end
      end
      ST_FIN:  if (!out_hold) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctl           = '0;
    ctl.mop       = MOP_BSPD;
    ctl.chan      = chan_r;
    ctl.busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: ctl.ld_step = in_valid;
      ST_MB: begin
        ctl.mul_en = 1'b1;
        ctl.mop    = MOP_BSPD;
      end
      ST_MS: begin
        ctl.mul_en = 1'b1;
        ctl.mop    = MOP_SSPD;
        ctl.upd_bp = 1'b1;
      end
      ST_B0: begin
        ctl.mul_en = 1'b1;
        ctl.mop    = MOP_BMIN;
        ctl.upd_sp = 1'b1;
      end
      ST_B1: begin
        ctl.mul_en = 1'b1;
        ctl.mop    = MOP_BMAX;
        ctl.ld_acc = 1'b1;
      end
      ST_S0: begin
        ctl.mul_en    = 1'b1;
        ctl.mop       = MOP_SMIN;
        ctl.ld_bright = 1'b1;
      end
      ST_S1: begin
        ctl.mul_en = 1'b1;
        ctl.mop    = MOP_SMAX;
        ctl.ld_acc = 1'b1;
      end
      ST_SAT: ctl.ld_sat = 1'b1;
      ST_CA: begin
        ctl.mul_en = 1'b1;
        ctl.mop    = MOP_BLEND;
        // product still holds the previous channel's scaled value
        ctl.ld_res = (chan_r != CH_RED);
      end
      ST_CB: ctl.ld_v = 1'b1;
      ST_CC: begin
        ctl.mul_en = 1'b1;
        ctl.mop    = MOP_SCALE;
      end
      ST_FIN:  ctl.ld_out = !out_hold;
      default: ctl.busy = 1'b1;
    endcase
  end

endmodule

/* hdl/rainbow_color_cycler.sv */
// ----------------------------------------------------------------------------
// rainbow_color_cycler: hue wheel color cycle generator
// Advances hue, brightness and saturation phases per tick and returns the
// resulting RGB color in Q1.15.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_phase_step): one transaction per
//   animation tick carrying the hue phase step, Q0.16 of a turn. in_stall is
//   high while a tick is being worked on.
//   Result channel (out_valid / out_stall / out_red, out_green, out_blue):
//   one transaction per tick, the color after the phase advance.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//   ready; write only while no tick is in flight. Unknown indexes are ignored.
// Timing:
//   A new tick is taken only once the previous one has reached the output
//   register. The tick rate is set by the single shared multiplier: 12
//   multiplies per tick, issued at most one per cycle by the sequencer,
//   plus level and blend steps between them.
// Reset:
//   Phases clear to zero, registers take their defaults (levels at one,
//   speeds at 1.0). No clearing pass is needed.
// Stall:
//   A finished color waits in the sequencer until the output register is
//   free; a held result is never overwritten, and no new tick is taken.
// ----------------------------------------------------------------------------
module rainbow_color_cycler #(
  parameter int PHASE_BITS = rcc_pkg::PHASE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // tick input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [15:0]                   in_phase_step,
  // color output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   out_red,
  output logic [15:0]                   out_green,
  output logic [15:0]                   out_blue,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  import rcc_pkg::*;

  localparam int AW = (PHASE_BITS > 16) ? PHASE_BITS : 16;
  localparam int PW = AW + 16;

  // Hue wheel segments
  localparam logic [2:0] SEG_RED_GREEN_UP  = 3'd0;
  localparam logic [2:0] SEG_RED_DOWN      = 3'd1;
  localparam logic [2:0] SEG_BLUE_UP       = 3'd2;
  localparam logic [2:0] SEG_GREEN_DOWN    = 3'd3;
  localparam logic [2:0] SEG_RED_UP        = 3'd4;

  ctl_t ctl;

  // Configuration registers
  logic [15:0] min_bright_r, max_bright_r, bright_speed_r;
  logic [15:0] min_sat_r, max_sat_r, sat_speed_r;

  // Phase state and working registers
  logic [PHASE_BITS-1:0] hue_r, bp_r, sp_r, step_r;
  logic [31:0]           acc_r;
  logic [15:0]           bright_r, sat_r, v_r, res0_r, res1_r;
  logic [15:0]           out_red_r, out_green_r, out_blue_r;
  logic                  out_valid_r;

  logic [PHASE_BITS+15:0] step_ext;
  logic [PHASE_BITS-1:0]  step_w;
  logic [PHASE_BITS+2:0]  hue_x6;
  logic [2:0]             seg;
  logic [PHASE_BITS+14:0] ramp_ext;
  logic [15:0]            ramp, inv;
  logic [15:0]            c_red, c_green, c_blue, c_sel;
  logic [15:0]            u_b, u_s;
  logic [AW-1:0]          mul_a;
  logic [15:0]            mul_b;
  logic [PW-1:0]          prod;
  logic [32:0]            lvl_sum;
  logic [15:0]            chan_val;

  rcc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_hold (out_valid_r && out_stall),
    .ctl      (ctl)
  );

  rcc_mul #(
    .A_W (AW),
    .B_W (16)
  ) u_mul (
    .clk (clk),
    .en  (ctl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Register writes, always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_bright_r   <= ONE_Q15;
      max_bright_r   <= ONE_Q15;
      bright_speed_r <= 16'd256;
      min_sat_r      <= ONE_Q15;
      max_sat_r      <= ONE_Q15;
      sat_speed_r    <= 16'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_BRIGHTNESS: min_bright_r   <= cfg_data;
        REG_MAX_BRIGHTNESS: max_bright_r   <= cfg_data;
        REG_BRIGHT_SPEED:   bright_speed_r <= cfg_data;
        REG_MIN_SATURATION: min_sat_r      <= cfg_data;
        REG_MAX_SATURATION: max_sat_r      <= cfg_data;
        REG_SAT_SPEED:      sat_speed_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Step widened to Q0.PHASE_BITS
  assign step_ext = {in_phase_step, PHASE_BITS'(0)};
  assign step_w   = step_ext[PHASE_BITS+15:16];

  // Hue wheel: segment and Q1.15 ramp from hue * 6
  assign hue_x6   = ({3'b000, hue_r} << 2) + ({3'b000, hue_r} << 1);
  assign seg      = hue_x6[PHASE_BITS+2:PHASE_BITS];
  assign ramp_ext = {hue_x6[PHASE_BITS-1:0], 15'd0};
  assign ramp     = {1'b0, ramp_ext[PHASE_BITS+14:PHASE_BITS]};
  assign inv      = ONE_Q15 - ramp;

  always_comb begin
    case (seg)
      SEG_RED_GREEN_UP: begin
        c_red = ONE_Q15; c_green = ramp;    c_blue = 16'd0;
      end
      SEG_RED_DOWN: begin
        c_red = inv;     c_green = ONE_Q15; c_blue = 16'd0;
      end
      SEG_BLUE_UP: begin
        c_red = 16'd0;   c_green = ONE_Q15; c_blue = ramp;
      end
      SEG_GREEN_DOWN: begin
        c_red = 16'd0;   c_green = inv;     c_blue = ONE_Q15;
      end
      SEG_RED_UP: begin
        c_red = ramp;    c_green = 16'd0;   c_blue = ONE_Q15;
      end
      default: begin
        c_red = ONE_Q15; c_green = 16'd0;   c_blue = inv;
      end
    endcase
  end

  // Channel being blended
  always_comb begin
    case (ctl.chan)
      CH_RED:   c_sel = c_red;
      CH_GREEN: c_sel = c_green;
      default:  c_sel = c_blue;
    endcase
  end

  // Raised sine of the top phase bits
  assign u_b = SINE_U_TABLE[bp_r[PHASE_BITS-1 -: SINE_IDX_BITS]];
  assign u_s = SINE_U_TABLE[sp_r[PHASE_BITS-1 -: SINE_IDX_BITS]];

  // Shared multiplier operand select
  always_comb begin
    case (ctl.mop)
      MOP_BSPD: begin
        mul_a = AW'(step_r);       mul_b = bright_speed_r;
      end
      MOP_SSPD: begin
        mul_a = AW'(step_r);       mul_b = sat_speed_r;
      end
      MOP_BMIN: begin
        mul_a = AW'(min_bright_r); mul_b = ONE_Q15 - u_b;
      end
      MOP_BMAX: begin
        mul_a = AW'(max_bright_r); mul_b = u_b;
      end
      MOP_SMIN: begin
        mul_a = AW'(min_sat_r);    mul_b = ONE_Q15 - u_s;
      end
      MOP_SMAX: begin
        mul_a = AW'(max_sat_r);    mul_b = u_s;
      end
      MOP_BLEND: begin
        mul_a = AW'(ONE_Q15 - c_sel); mul_b = ONE_Q15 - sat_r;
      end
      default: begin
        mul_a = AW'(v_r);          mul_b = bright_r;
      end
    endcase
  end

  assign lvl_sum  = {1'b0, acc_r} + {1'b0, prod[31:0]};
  assign chan_val = prod[30:15];

  // Phase state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_r <= '0;
      bp_r  <= '0;
      sp_r  <= '0;
    end else begin
      if (ctl.ld_step) hue_r <= hue_r + step_w;
      if (ctl.upd_bp)  bp_r  <= bp_r + prod[PHASE_BITS+7:8];
      if (ctl.upd_sp)  sp_r  <= sp_r + prod[PHASE_BITS+7:8];
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (ctl.ld_step)   step_r   <= step_w;
    if (ctl.ld_acc)    acc_r    <= prod[31:0];
    if (ctl.ld_bright) bright_r <= level_sat(lvl_sum);
    if (ctl.ld_sat)    sat_r    <= level_sat(lvl_sum);
    if (ctl.ld_v)      v_r      <= c_sel + chan_val;
    if (ctl.ld_res && ctl.chan == CH_GREEN) res0_r <= chan_val;
    if (ctl.ld_res && ctl.chan == CH_BLUE)  res1_r <= chan_val;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      out_red_r   <= res0_r;
      out_green_r <= res1_r;
      out_blue_r  <= chan_val;
    end
  end

  assign in_stall  = ctl.busy;
  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

`ifndef NO_ASSERTIONS
  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ld_out |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  // An accepted tick puts the sequencer to work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> ctl.busy)
    else $error("tick accepted but sequencer idle");

  // Brightness level never exceeds one
  a_bright_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ld_bright |=> (bright_r <= ONE_Q15))
    else $error("brightness level above one");

  // Saturation level never exceeds one
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ld_sat |=> (sat_r <= ONE_Q15))
    else $error("saturation level above one");

  // Delivered channels stay within Q1.15 one
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red <= ONE_Q15 && out_green <= ONE_Q15 && out_blue <= ONE_Q15))
    else $error("channel above one");
`endif

endmodule
